@@ sv/pixel_format_converter_macros.svh @@
// ---------------------------------------------------------------------------
// Pixel format converter assertion macros
// Shared macros for the concurrent checks of the converter.
// ---------------------------------------------------------------------------
`ifndef PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define PIXEL_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel_format_converter check failed");

// Next-cycle implication, disabled during reset.
`define PFC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel_format_converter check failed");

// Next-cycle implication that is also checked across reset.
`define PFC_ASSERT_RST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pixel_format_converter check failed");

`endif

@@ sv/pfc_pkg.sv @@
// ---------------------------------------------------------------------------
// Pixel format converter package
// Format codes, configuration type, float helpers and u8-to-float tables.
// ---------------------------------------------------------------------------
package pfc_pkg;

   localparam logic [3:0] FMT_ARGB8 = 4'd0;
   localparam logic [3:0] FMT_ABGR8 = 4'd1;
   localparam logic [3:0] FMT_BGRA8 = 4'd2;
   localparam logic [3:0] FMT_RGBA8 = 4'd3;
   localparam logic [3:0] FMT_XRGB8 = 4'd4;
   localparam logic [3:0] FMT_XBGR8 = 4'd5;
   localparam logic [3:0] FMT_RGB8  = 4'd6;
   localparam logic [3:0] FMT_BGR8  = 4'd7;
   localparam logic [3:0] FMT_L8    = 4'd8;
   localparam logic [3:0] FMT_L16   = 4'd9;
   localparam logic [3:0] FMT_F32X4 = 4'd10;
   localparam logic [3:0] FMT_F16X4 = 4'd11;

   localparam logic CSR_SOURCE_FORMAT = 1'b0;
   localparam logic CSR_TARGET_FORMAT = 1'b1;

   typedef struct packed {
      logic [3:0] source_format;
      logic [3:0] target_format;
   } cfg_type;

   typedef logic [31:0] f32_table_type [256];
   typedef logic [15:0] f16_table_type [256];

   function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
      logic       s;
      logic [4:0] e;
      logic [9:0] m;
      logic [3:0] pos;
      logic [9:0] mn;
      s   = h[15];
      e   = h[14:10];
      m   = h[9:0];
      pos = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            pos = 4'(i);
         end
      end
      mn = 10'(m << (4'd10 - pos));
      if (e == 5'd0) begin
         if (m == 10'd0) begin
            return {s, 31'd0};
         end
         return {s, 8'(8'd103 + {4'd0, pos}), mn, 13'd0};
      end
      if (e == 5'h1F) begin
         return {s, 8'hFF, m, 13'd0};
      end
      return {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
   endfunction

   function automatic logic [15:0] f32_to_f16(input logic [31:0] f);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [23:0] mm;
      logic [4:0]  sh;
      logic [23:0] hm;
      logic [23:0] rem;
      logic [23:0] half;
      logic [14:0] hn;
      logic        up;
      s  = f[31];
      e  = f[30:23];
      m  = f[22:0];
      mm = {1'b1, m};
      if (e == 8'hFF) begin
         return {s, 5'h1F, (m != 23'd0), (m != 23'd0) ? m[21:13] : 9'd0};
      end
      if (e >= 8'd143) begin
         return {s, 15'h7C00};
      end
      if (e <= 8'd112) begin
         if (e < 8'd102) begin
            return {s, 15'd0};
         end
         sh   = 5'(8'd126 - e);
         hm   = mm >> sh;
         half = 24'd1 << (sh - 5'd1);
         rem  = mm & ((24'd1 << sh) - 24'd1);
         up   = (rem > half) || ((rem == half) && hm[0]);
         return {s, 15'(hm + {23'd0, up})};
      end
      hn = {5'(e - 8'd112), m[22:13]};
      up = (m[12:0] > 13'h1000) || ((m[12:0] == 13'h1000) && hn[0]);
      return {s, 15'(hn + {14'd0, up})};
   endfunction

   function automatic logic [7:0] f32_to_u8(input logic [31:0] f);
      logic [7:0]  e;
      logic [23:0] mm;
      logic [31:0] p;
      logic [32:0] pr;
      logic [7:0]  sa;
      logic        up;
      logic [32:0] shifted;
      e  = f[30:23];
      mm = {(e != 8'd0), f[22:0]};
      p  = 32'({8'd0, mm} * 32'd255);
      if (p[31]) begin
         up = p[7] && ((p[6:0] != 7'd0) || p[8]);
         pr = 33'({1'b0, p[31:8]} + {24'd0, up}) << 8;
      end else begin
         up = p[6] && ((p[5:0] != 6'd0) || p[7]);
         pr = 33'({1'b0, p[31:7]} + {25'd0, up}) << 7;
      end
      sa      = 8'(8'd150 - e);
      shifted = pr >> sa;
      if (f[31]) begin
         return 8'd0;
      end
      if (e == 8'hFF) begin
         return (f[22:0] != 23'd0) ? 8'd0 : 8'd255;
      end
      if (e >= 8'd127) begin
         return 8'd255;
      end
      return shifted[7:0];
   endfunction

   function automatic f32_table_type build_f32_table();
      f32_table_type t;
      logic [63:0]   q;
      logic [24:0]   mant;
      int            p;
      for (int b = 0; b < 256; b++) begin
         if (b == 0) begin
            t[b] = 32'd0;
         end else if (b == 255) begin
            t[b] = 32'h3F80_0000;
         end else begin
            q = (64'(b) << 40) / 64'd255;
            p = 0;
            for (int i = 0; i < 64; i++) begin
               if (q[i]) begin
                  p = i;
               end
            end
            mant = 25'(q >> (p - 23)) + 25'(q[p - 24]);
            if (mant[24]) begin
               mant = mant >> 1;
               p    = p + 1;
            end
            t[b] = {1'b0, 8'(p + 87), mant[22:0]};
         end
      end
      return t;
   endfunction

   localparam f32_table_type U8_TO_F32 = build_f32_table();

   function automatic f16_table_type build_f16_table();
      f16_table_type t;
      for (int b = 0; b < 256; b++) begin
         t[b] = f32_to_f16(U8_TO_F32[b]);
      end
      return t;
   endfunction

   localparam f16_table_type U8_TO_F16 = build_f16_table();

endpackage

@@ sv/pfc_convert.sv @@
// ---------------------------------------------------------------------------
// Pixel format converter datapath
// Combinational conversion of one pixel for the configured format pair.
// ---------------------------------------------------------------------------
module pfc_convert
   import pfc_pkg::*;
(
   input  cfg_type     cfg,
   input  logic [63:0] pixel_low,
   input  logic [63:0] pixel_high,
   output logic [63:0] result_low,
   output logic [63:0] result_high,
   output logic        supported
);

   logic [7:0] x, y, z, w;
   logic [7:0] ch0, ch1, ch2, ch3;
   logic [7:0] hc0, hc1, hc2, hc3;

   assign x = pixel_low[7:0];
   assign y = pixel_low[15:8];
   assign z = pixel_low[23:16];
   assign w = pixel_low[31:24];

   assign ch0 = f32_to_u8(pixel_low[31:0]);
   assign ch1 = f32_to_u8(pixel_low[63:32]);
   assign ch2 = f32_to_u8(pixel_high[31:0]);
   assign ch3 = f32_to_u8(pixel_high[63:32]);

   assign hc0 = f32_to_u8(f16_to_f32(pixel_low[15:0]));
   assign hc1 = f32_to_u8(f16_to_f32(pixel_low[31:16]));
   assign hc2 = f32_to_u8(f16_to_f32(pixel_low[47:32]));
   assign hc3 = f32_to_u8(f16_to_f32(pixel_low[63:48]));

   always_comb begin
      result_low  = 64'd0;
      result_high = 64'd0;
      supported   = 1'b1;
      case ({cfg.source_format, cfg.target_format})
         {FMT_ARGB8, FMT_ABGR8}: result_low = {32'd0, w, x, y, z};
         {FMT_ARGB8, FMT_BGRA8}: result_low = {32'd0, x, y, z, w};
         {FMT_ARGB8, FMT_RGBA8}: result_low = {32'd0, z, y, x, w};
         {FMT_ABGR8, FMT_ARGB8}: result_low = {32'd0, w, x, y, z};
         {FMT_ABGR8, FMT_BGRA8}: result_low = {32'd0, z, y, x, w};
         {FMT_ABGR8, FMT_RGBA8}: result_low = {32'd0, x, y, z, w};
         {FMT_BGRA8, FMT_ARGB8}: result_low = {32'd0, x, y, z, w};
         {FMT_BGRA8, FMT_ABGR8}: result_low = {32'd0, x, w, z, y};
         {FMT_BGRA8, FMT_RGBA8}: result_low = {32'd0, y, z, w, x};
         {FMT_RGBA8, FMT_ARGB8}: result_low = {32'd0, x, w, z, y};
         {FMT_RGBA8, FMT_ABGR8}: result_low = {32'd0, x, y, z, w};
         {FMT_RGBA8, FMT_BGRA8}: result_low = {32'd0, y, z, w, x};
         {FMT_ABGR8, FMT_L8}:    result_low = {56'd0, x};
         {FMT_ARGB8, FMT_L8}:    result_low = {56'd0, z};
         {FMT_BGRA8, FMT_L8}:    result_low = {56'd0, y};
         {FMT_L8, FMT_ABGR8},
         {FMT_L8, FMT_ARGB8}:    result_low = {32'd0, 8'hFF, x, x, x};
         {FMT_L8, FMT_BGRA8}:    result_low = {32'd0, x, x, x, 8'hFF};
         {FMT_L8, FMT_L16}:      result_low = {48'd0, x, x};
         {FMT_L16, FMT_L8}:      result_low = {56'd0, y};
         {FMT_BGR8, FMT_RGB8},
         {FMT_RGB8, FMT_BGR8}:   result_low = {40'd0, x, y, z};
         {FMT_RGB8, FMT_XRGB8},
         {FMT_RGB8, FMT_ARGB8}:  result_low = {32'd0, 8'hFF, z, y, x};
         {FMT_BGR8, FMT_ARGB8},
         {FMT_RGB8, FMT_ABGR8}:  result_low = {32'd0, 8'hFF, x, y, z};
         {FMT_BGR8, FMT_ABGR8}:  result_low = {32'd0, 8'hFF, z, y, x};
         {FMT_RGB8, FMT_BGRA8}:  result_low = {32'd0, x, y, z, 8'hFF};
         {FMT_BGR8, FMT_BGRA8}:  result_low = {32'd0, z, y, x, 8'hFF};
         {FMT_ARGB8, FMT_RGB8}:  result_low = {40'd0, x, y, z};
         {FMT_ARGB8, FMT_BGR8}:  result_low = {40'd0, z, y, x};
         {FMT_XRGB8, FMT_ARGB8},
         {FMT_XBGR8, FMT_ABGR8}: result_low = {32'd0, 8'hFF, z, y, x};
         {FMT_XRGB8, FMT_ABGR8},
         {FMT_XBGR8, FMT_ARGB8}: result_low = {32'd0, 8'hFF, x, y, z};
         {FMT_XRGB8, FMT_BGRA8},
         {FMT_XBGR8, FMT_RGBA8}: result_low = {32'd0, x, y, z, 8'hFF};
         {FMT_XRGB8, FMT_RGBA8},
         {FMT_XBGR8, FMT_BGRA8}: result_low = {32'd0, z, y, x, 8'hFF};
         {FMT_ARGB8, FMT_F32X4}: begin
            result_low  = {U8_TO_F32[z], U8_TO_F32[w]};
            result_high = {U8_TO_F32[x], U8_TO_F32[y]};
         end
         {FMT_F32X4, FMT_ARGB8}: result_low = {32'd0, ch0, ch1, ch2, ch3};
         {FMT_F16X4, FMT_F32X4}: begin
            result_low  = {f16_to_f32(pixel_low[31:16]), f16_to_f32(pixel_low[15:0])};
            result_high = {f16_to_f32(pixel_low[63:48]), f16_to_f32(pixel_low[47:32])};
         end
         {FMT_F32X4, FMT_F16X4}: begin
            result_low = {f32_to_f16(pixel_high[63:32]), f32_to_f16(pixel_high[31:0]),
                          f32_to_f16(pixel_low[63:32]), f32_to_f16(pixel_low[31:0])};
         end
         {FMT_ARGB8, FMT_F16X4}: begin
            result_low = {U8_TO_F16[x], U8_TO_F16[y], U8_TO_F16[z], U8_TO_F16[w]};
         end
         {FMT_F16X4, FMT_ARGB8}: result_low = {32'd0, hc0, hc1, hc2, hc3};
         default: begin
            supported = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/pixel_format_converter.sv @@
// ---------------------------------------------------------------------------
// Pixel format converter
// Converts one pixel per beat between twelve byte, luminance and float formats.
// ---------------------------------------------------------------------------
// The req_ channel carries one source pixel per beat in req_pixel_low and
// req_pixel_high. The rsp_ channel returns the converted pixel and a
// supported flag; an unsupported format pair returns a zero pixel.
// The csr_ port sets source_format (index 0) and target_format (index 1);
// write it only while no beat is in flight.
// A beat goes through an input register and then a result register, which
// presents it on the rsp_ channel; one beat is taken per cycle as long as
// rsp_ready is high. The conversion logic between the two registers sets
// the clock rate.
// When the receiver stalls, the result register holds and the input register
// fills; req_ready then drops until the result is taken.
// Reset empties both registers and sets both formats to ARGB8.
// ---------------------------------------------------------------------------
module pixel_format_converter
   import pfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_pixel_low,
   input  logic [63:0] req_pixel_high,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_low,
   output logic [63:0] rsp_result_high,
   output logic        rsp_supported,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        in_valid_ff, in_valid_in;
   logic [63:0] in_low_ff, in_high_ff;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_low_ff, out_high_ff;
   logic        out_supported_ff;
   logic        out_take;
   logic        in_take;
   logic [63:0] conv_low, conv_high;
   logic        conv_supported;

   assign out_take  = !out_valid_ff || rsp_ready;
   assign in_take   = !in_valid_ff || out_take;
   assign req_ready = in_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_FORMAT: cfg_in.source_format = csr_write_data;
            CSR_TARGET_FORMAT: cfg_in.target_format = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign in_valid_in  = in_take ? req_valid : in_valid_ff;
   assign out_valid_in = out_take ? in_valid_ff : out_valid_ff;

   pfc_convert u_convert (
      .cfg         (cfg_ff),
      .pixel_low   (in_low_ff),
      .pixel_high  (in_high_ff),
      .result_low  (conv_low),
      .result_high (conv_high),
      .supported   (conv_supported)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req_valid) begin
         in_low_ff  <= req_pixel_low;
         in_high_ff <= req_pixel_high;
      end
      if (out_take && in_valid_ff) begin
         out_low_ff       <= conv_low;
         out_high_ff      <= conv_high;
         out_supported_ff <= conv_supported;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result_low  = out_low_ff;
   assign rsp_result_high = out_high_ff;
   assign rsp_supported   = out_supported_ff;

endmodule

@@ sv/pfc_checker.sv @@
// ---------------------------------------------------------------------------
// Pixel format converter checker
// Port-level checks of the converter, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "pixel_format_converter_macros.svh"

module pfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_result_low,
   input logic [63:0] rsp_result_high,
   input logic        rsp_supported
);

   `PFC_ASSERT_RST(a_reset_empties, clock, reset, !rsp_valid)
   `PFC_ASSERT_IMP(a_ready_follows, clock, reset, rsp_ready, req_ready)
   `PFC_ASSERT_IMP(a_unsupported_zero, clock, reset, rsp_valid && !rsp_supported,
      (rsp_result_low == 64'd0) && (rsp_result_high == 64'd0))
   `PFC_ASSERT_NXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_result_low) && $stable(rsp_result_high))

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_low  (rsp_result_low),
   .rsp_result_high (rsp_result_high),
   .rsp_supported   (rsp_supported)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Pixel format converter testbench
// Sweeps every source and target format code, including the unused codes,
// and drives pixels through the req_ channel with random idle cycles on
// both sides. Each returned beat is checked against a bit-exact integer
// model of the byte swizzles, the u8 and float conversions and the binary16
// rounding.
// ---------------------------------------------------------------------------
module tb_top;
   import pfc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [63:0] low;
      logic [63:0] high;
   } pixel_type;

   typedef struct {
      logic [63:0] low;
      logic [63:0] high;
      logic        supported;
   } converted_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_pixel_low = '0;
   logic [63:0] req_pixel_high = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_result_low;
   logic [63:0] rsp_result_high;
   logic        rsp_supported;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_SOURCE_FORMAT;
   logic [3:0]  csr_write_data = '0;

   pixel_type     pending_pixels[$];
   converted_type expected_pixels[$];
   logic [3:0] src_fmt = FMT_ARGB8;
   logic [3:0] dst_fmt = FMT_ARGB8;
   logic       req_taken = 1'b0;
   logic       failed = 1'b0;
   int         cycle_count = 0;

   pixel_format_converter dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] swap_bytes_02(input logic [31:0] u);
      return {u[31:24], u[7:0], u[15:8], u[23:16]};
   endfunction

   function automatic logic [31:0] swap_bytes_13(input logic [31:0] u);
      return {u[15:8], u[23:16], u[31:24], u[7:0]};
   endfunction

   function automatic logic [31:0] reverse_bytes(input logic [31:0] u);
      return {u[7:0], u[15:8], u[23:16], u[31:24]};
   endfunction

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [10:0] mw;
      int          ex;
      mw = {1'b0, h[9:0]};
      ex = 113;
      if (h[14:10] == 5'd0) begin
         if (mw == 11'd0) begin
            return {h[15], 31'd0};
         end
         while (!mw[10]) begin
            mw = mw << 1;
            ex = ex - 1;
         end
         return {h[15], 8'(ex), mw[9:0], 13'd0};
      end
      if (h[14:10] == 5'h1F) begin
         return {h[15], 8'hFF, h[9:0], 13'd0};
      end
      return {h[15], 8'({3'd0, h[14:10]} + 8'd112), h[9:0], 13'd0};
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] f);
      logic [23:0] m;
      logic [23:0] hm;
      logic [23:0] rem;
      logic [23:0] mid;
      int          ex;
      int          sh;
      m  = {1'b0, f[22:0]};
      ex = int'(f[30:23]) - 112;
      if (f[30:23] == 8'hFF) begin
         return {f[31], 5'h1F, (m != 24'd0) ? {1'b1, m[21:13]} : 10'd0};
      end
      if (ex >= 31) begin
         return {f[31], 15'h7C00};
      end
      if (ex <= 0) begin
         if (ex < -10) begin
            return {f[31], 15'd0};
         end
         m   = m | 24'h800000;
         sh  = 14 - ex;
         hm  = m >> sh;
         rem = m & ((24'd1 << sh) - 24'd1);
         mid = 24'd1 << (sh - 1);
      end else begin
         hm  = {9'd0, 5'(ex), m[22:13]};
         rem = {11'd0, m[12:0]};
         mid = 24'h1000;
      end
      if (rem > mid || (rem == mid && hm[0])) begin
         hm = hm + 24'd1;
      end
      return {f[31], hm[14:0]};
   endfunction

   // Correctly rounded b / 255 in single precision, done in integers.
   function automatic logic [31:0] u8_to_single(input logic [7:0] b);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] low;
      logic [63:0] mid;
      logic [24:0] mant;
      int          p;
      if (b == 8'd0) begin
         return 32'd0;
      end
      q = (64'(b) << 48) / 64'd255;
      r = (64'(b) << 48) % 64'd255;
      p = 0;
      for (int i = 0; i < 64; i++) begin
         if (q[i]) begin
            p = i;
         end
      end
      mant = 25'(q >> (p - 23));
      low  = q & ((64'd1 << (p - 23)) - 64'd1);
      mid  = 64'd1 << (p - 24);
      if (low > mid || (low == mid && (r != 64'd0 || mant[0]))) begin
         mant = mant + 25'd1;
      end
      if (mant[24]) begin
         mant = mant >> 1;
         p    = p + 1;
      end
      return {1'b0, 8'(p + 79), mant[22:0]};
   endfunction

   // Saturate to [0,1], round v*255 to single precision, then truncate.
   function automatic logic [7:0] single_to_u8(input logic [31:0] f);
      logic [47:0] prod;
      logic [47:0] keep;
      logic [47:0] low;
      logic [47:0] mid;
      int          top;
      int          k;
      int          sh;
      if (f[31] || f[30:0] == 31'd0) begin
         return 8'd0;
      end
      if (f[30:23] == 8'hFF) begin
         return (f[22:0] != 23'd0) ? 8'd0 : 8'd255;
      end
      if (f[30:23] >= 8'd127) begin
         return 8'd255;
      end
      prod = 48'({f[30:23] != 8'd0, f[22:0]}) * 48'd255;
      top  = 0;
      for (int i = 0; i < 48; i++) begin
         if (prod[i]) begin
            top = i;
         end
      end
      if (top > 23) begin
         k    = top - 23;
         keep = prod >> k;
         low  = prod & ((48'd1 << k) - 48'd1);
         mid  = 48'd1 << (k - 1);
         if (low > mid || (low == mid && keep[0])) begin
            keep = keep + 48'd1;
         end
         prod = keep << k;
      end
      sh = 150 - ((f[30:23] == 8'd0) ? 1 : int'(f[30:23]));
      if (sh >= 48) begin
         return 8'd0;
      end
      return 8'(prod >> sh);
   endfunction

   function automatic converted_type convert_pixel(input logic [3:0] sf, input logic [3:0] tf,
                                                   input logic [63:0] lo, input logic [63:0] hi);
      converted_type c;
      logic [31:0] u;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  z;
      logic [7:0]  ch[4];
      u = lo[31:0];
      x = u[7:0];
      y = u[15:8];
      z = u[23:16];
      c.low       = '0;
      c.high      = '0;
      c.supported = 1'b1;
      case ({sf, tf})
         {FMT_ARGB8, FMT_ABGR8}, {FMT_ABGR8, FMT_ARGB8}: c.low = 64'(swap_bytes_02(u));
         {FMT_ARGB8, FMT_BGRA8}, {FMT_ABGR8, FMT_RGBA8}, {FMT_BGRA8, FMT_ARGB8},
         {FMT_RGBA8, FMT_ABGR8}: c.low = 64'(reverse_bytes(u));
         {FMT_ARGB8, FMT_RGBA8}, {FMT_ABGR8, FMT_BGRA8}: c.low = 64'({u[23:0], u[31:24]});
         {FMT_BGRA8, FMT_ABGR8}, {FMT_RGBA8, FMT_ARGB8}: c.low = 64'({u[7:0], u[31:8]});
         {FMT_BGRA8, FMT_RGBA8}, {FMT_RGBA8, FMT_BGRA8}: c.low = 64'(swap_bytes_13(u));
         {FMT_ABGR8, FMT_L8}: c.low = 64'(x);
         {FMT_ARGB8, FMT_L8}: c.low = 64'(z);
         {FMT_BGRA8, FMT_L8}: c.low = 64'(y);
         {FMT_L8, FMT_ABGR8}, {FMT_L8, FMT_ARGB8}: c.low = 64'({8'hFF, x, x, x});
         {FMT_L8, FMT_BGRA8}: c.low = 64'({x, x, x, 8'hFF});
         {FMT_L8, FMT_L16}: c.low = 64'({x, x});
         {FMT_L16, FMT_L8}: c.low = 64'(y);
         {FMT_BGR8, FMT_RGB8}, {FMT_RGB8, FMT_BGR8}, {FMT_ARGB8, FMT_RGB8}:
            c.low = 64'({x, y, z});
         {FMT_RGB8, FMT_XRGB8}, {FMT_RGB8, FMT_ARGB8}, {FMT_BGR8, FMT_ABGR8}:
            c.low = 64'({8'hFF, z, y, x});
         {FMT_BGR8, FMT_ARGB8}, {FMT_RGB8, FMT_ABGR8}: c.low = 64'({8'hFF, x, y, z});
         {FMT_RGB8, FMT_BGRA8}: c.low = 64'({x, y, z, 8'hFF});
         {FMT_BGR8, FMT_BGRA8}: c.low = 64'({z, y, x, 8'hFF});
         {FMT_ARGB8, FMT_BGR8}: c.low = 64'({z, y, x});
         {FMT_XRGB8, FMT_ARGB8}, {FMT_XBGR8, FMT_ABGR8}: c.low = 64'({8'hFF, z, y, x});
         {FMT_XRGB8, FMT_ABGR8}, {FMT_XBGR8, FMT_ARGB8}: c.low = 64'({8'hFF, x, y, z});
         {FMT_XRGB8, FMT_BGRA8}, {FMT_XBGR8, FMT_RGBA8}: c.low = 64'({x, y, z, 8'hFF});
         {FMT_XRGB8, FMT_RGBA8}, {FMT_XBGR8, FMT_BGRA8}: c.low = 64'({z, y, x, 8'hFF});
         {FMT_ARGB8, FMT_F32X4}: begin
            c.low  = {u8_to_single(z), u8_to_single(u[31:24])};
            c.high = {u8_to_single(x), u8_to_single(y)};
         end
         {FMT_F32X4, FMT_ARGB8}:
            c.low = 64'({single_to_u8(lo[31:0]), single_to_u8(lo[63:32]),
                         single_to_u8(hi[31:0]), single_to_u8(hi[63:32])});
         {FMT_F16X4, FMT_F32X4}: begin
            c.low  = {half_to_single(lo[31:16]), half_to_single(lo[15:0])};
            c.high = {half_to_single(lo[63:48]), half_to_single(lo[47:32])};
         end
         {FMT_F32X4, FMT_F16X4}:
            c.low = {single_to_half(hi[63:32]), single_to_half(hi[31:0]),
                     single_to_half(lo[63:32]), single_to_half(lo[31:0])};
         {FMT_ARGB8, FMT_F16X4}:
            c.low = {single_to_half(u8_to_single(x)), single_to_half(u8_to_single(y)),
                     single_to_half(u8_to_single(z)), single_to_half(u8_to_single(u[31:24]))};
         {FMT_F16X4, FMT_ARGB8}: begin
            for (int i = 0; i < 4; i++) begin
               ch[i] = single_to_u8(half_to_single(lo[16 * i +: 16]));
            end
            c.low = 64'({ch[0], ch[1], ch[2], ch[3]});
         end
         default: c.supported = 1'b0;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] random_single();
      logic [31:0] f;
      f = $urandom;
      case ($urandom_range(0, 5))
         0: ;
         1: f[30:23] = 8'($urandom_range(100, 127));
         2: f[30:23] = 8'($urandom_range(98, 114));
         3: f[30:23] = 8'($urandom_range(140, 145));
         4: f[30:23] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: f = ($urandom_range(0, 1) != 0) ? 32'h3F80_0000 : u8_to_single(8'($urandom));
      endcase
      if ($urandom_range(0, 3) != 0 && f[30:23] != 8'hFF) begin
         f[31] = 1'b0;
      end
      return f;
   endfunction

   function automatic logic [15:0] random_half();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(0, 3))
         0: ;
         1: h[14:10] = 5'($urandom_range(8, 15));
         2: h[14:10] = ($urandom_range(0, 1) != 0) ? 5'h1F : 5'h00;
         default: h[15] = 1'b0;
      endcase
      return h;
   endfunction

   function automatic pixel_type random_pixel(input logic [3:0] sf);
      pixel_type p;
      p.low  = {$urandom, $urandom};
      p.high = {$urandom, $urandom};
      if (sf == FMT_F32X4) begin
         p.low  = {random_single(), random_single()};
         p.high = {random_single(), random_single()};
      end else if (sf == FMT_F16X4) begin
         p.low = {random_half(), random_half(), random_half(), random_half()};
      end else if ($urandom_range(0, 15) == 0) begin
         p.low  = ($urandom_range(0, 1) != 0) ? '1 : '0;
         p.high = ~p.low;
      end
      return p;
   endfunction

   task automatic write_csr(input logic idx, input logic [3:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx == CSR_SOURCE_FORMAT) begin
         src_fmt = value;
      end else begin
         dst_fmt = value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_formats(input logic [3:0] sf, input logic [3:0] tf);
      write_csr(CSR_SOURCE_FORMAT, sf);
      write_csr(CSR_TARGET_FORMAT, tf);
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
         #1;
      end while (pending_pixels.size() != 0 || (req_valid && !req_taken) ||
                 expected_pixels.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_pixel(input logic [63:0] lo, input logic [63:0] hi);
      pixel_type p;
      p.low  = lo;
      p.high = hi;
      pending_pixels.push_back(p);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      set_formats(FMT_F32X4, FMT_F16X4);
      push_pixel({32'h7FC0_0001, 32'h7F80_0000}, {32'hC780_0000, 32'h3300_0000});
      push_pixel({32'h32FF_FFFF, 32'h3880_0000}, {32'hFF80_0001, 32'h3F80_1000});
      push_pixel({32'h3300_0001, 32'h4780_0000}, {32'h477F_F000, 32'h8000_0000});
      wait_idle();
      set_formats(FMT_F16X4, FMT_F32X4);
      push_pixel(64'h0001_7C01_FC00_03FF, '1);
      push_pixel(64'h7BFF_0400_8000_0000, '0);
      wait_idle();
      set_formats(FMT_F32X4, FMT_ARGB8);
      push_pixel({32'h3F00_0000, 32'h7FC0_0000}, {32'h4000_0000, 32'hBF80_0000});
      push_pixel({32'h3F7F_FFFF, 32'h7F80_0000}, {32'h3F80_0000, 32'h0000_0001});
      wait_idle();
      set_formats(FMT_F16X4, FMT_ARGB8);
      push_pixel(64'h3C00_7E00_BC00_3800, '0);
      push_pixel(64'h0001_7C00_3BFF_0000, '1);
      wait_idle();
      set_formats(FMT_ARGB8, FMT_F16X4);
      push_pixel(64'h0000_0000_FF80_7F01, '0);
      push_pixel('1, '1);
      wait_idle();
      set_formats(FMT_ARGB8, FMT_F32X4);
      push_pixel(64'h0000_0000_00FF_0180, '0);
      push_pixel(64'hFFFF_FFFF_A55A_C33C, '1);
      wait_idle();

      for (int s = 0; s < 16; s++) begin
         for (int t = 0; t < 16; t++) begin
            set_formats(4'(s), 4'(t));
            repeat ($urandom_range(1, 13)) begin
               pending_pixels.push_back(random_pixel(4'(s)));
            end
            wait_idle();
         end
      end

      repeat (8) @(negedge clock);
      if (!failed) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   always @(negedge clock) begin
      pixel_type p;
      logic      quiet;
      quiet = cycle_count > 3000 && cycle_count < 5000;
      rsp_ready <= !reset && (quiet || $urandom_range(0, 99) >= 28);
      if (!req_valid || req_taken) begin
         if (!reset && pending_pixels.size() != 0 &&
             (quiet || $urandom_range(0, 99) >= 28)) begin
            p = pending_pixels.pop_front();
            req_valid      <= 1'b1;
            req_pixel_low  <= p.low;
            req_pixel_high <= p.high;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      converted_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_pixels.push_back(convert_pixel(src_fmt, dst_fmt,
                                                    req_pixel_low, req_pixel_high));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result beat with nothing expected");
               failed = 1'b1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_result_low !== want.low) begin
                  $error("result_low: expected %h, actual %h", want.low, rsp_result_low);
                  failed = 1'b1;
               end
               if (rsp_result_high !== want.high) begin
                  $error("result_high: expected %h, actual %h", want.high, rsp_result_high);
                  failed = 1'b1;
               end
               if (rsp_supported !== want.supported) begin
                  $error("supported: expected %b, actual %b", want.supported, rsp_supported);
                  failed = 1'b1;
               end
            end
         end
      end
   end

endmodule
